// ----- rtl/svbg_pkg.sv -----
// ----------------------------------------------------------------------------
// svbg_pkg
// Shared types, constants and helpers for the sphere voxel brightness block.
// ----------------------------------------------------------------------------
package svbg_pkg;

    localparam int CUBE_EDGE = 4;
    localparam int COORD_W   = 2;
    localparam int DIST_W    = 5;
    localparam int SIZE_W    = 11;
    localparam int STEP_W    = 9;
    localparam int BRIGHT_W  = 8;
    localparam int SQ_W      = 2 * SIZE_W;
    localparam int MUL_A_W   = 22;
    localparam int MUL_B_W   = 16;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SEARCH_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [COORD_W-1:0]  EDGE_MAX    = COORD_W'(CUBE_EDGE - 1);
    localparam logic [SIZE_W-1:0]   SIZE_LIMIT  = 11'd1280;
    localparam logic [STEP_W-1:0]   GROW_RESET  = 9'd102;
    localparam logic [MUL_B_W-1:0]  FULL_SCALE  = 16'd65025;
    localparam logic [BRIGHT_W-1:0] BRIGHT_ON   = 8'd255;
    localparam logic [BRIGHT_W-1:0] BRIGHT_OFF  = 8'd0;
    localparam logic [BRIGHT_W-1:0] BRIGHT_NEAR = 8'd254;

    localparam logic [CFG_IDX_W-1:0] REG_GROW_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_SIZE,
        ST_SQ_SCALE,
        ST_Q_LATCH,
        ST_VOX_START,
        ST_MUL_MID,
        ST_MUL_S,
        ST_CMP,
        ST_FINISH,
        ST_EMIT,
        ST_UPDATE
    } svbg_state_t;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [BRIGHT_W-1:0] brightness;
        logic                last;
    } voxel_t;

    // Squared distance from the cube center, in units of half a voxel pitch.
    function automatic logic [DIST_W-1:0] dist_sq(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        int a;
        int b;
        int c;
        a = 2 * int'(x) - (CUBE_EDGE - 1);
        b = 2 * int'(y) - (CUBE_EDGE - 1);
        c = 2 * int'(z) - (CUBE_EDGE - 1);
        return DIST_W'(a * a + b * b + c * c);
    endfunction

endpackage

// ----- rtl/svbg_engine.sv -----
// ----------------------------------------------------------------------------
// svbg_engine
// Frame sequencer and per-voxel brightness search around one shared multiplier.
// ----------------------------------------------------------------------------
module svbg_engine
    import svbg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                restart,
    output logic                ready,
    input  logic [STEP_W-1:0]   grow_step,
    input  logic                falloff_enable,
    output logic                vox_valid,
    output voxel_t              vox,
    input  logic                vox_ready
);

    svbg_state_t state_reg;
    svbg_state_t state_next;

    logic [SIZE_W-1:0]   size_reg;
    logic                inv_reg;
    logic [SQ_W-1:0]     size2_reg;
    logic [PROD_W-1:0]   q_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [COORD_W-1:0]  z_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [BRIGHT_W-1:0] b_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [SEARCH_W-1:0] step_reg;
    logic                eq_reg;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [DIST_W-1:0]   dist_cur;
    logic [BRIGHT_W-1:0] trial;
    logic [PROD_W-1:0]   lhs;
    logic                last_vox;
    logic                saturated;
    logic                big;

    assign mul_p     = mul_a * mul_b;
    assign dist_cur  = dist_sq(x_reg, y_reg, z_reg);
    assign trial     = b_reg | (BRIGHT_W'(1) << step_reg);
    assign lhs       = {3'b0, prod_reg[20:0], 14'b0};
    assign last_vox  = (x_reg == EDGE_MAX) && (y_reg == EDGE_MAX) && (z_reg == EDGE_MAX);
    // The ratio exceeds one when size^2 > 2^14 * dist, and one half when size^2 > 2^12 * dist.
    assign saturated = (dist_cur == '0) || (size2_reg > {3'b0, dist_cur, 14'b0});
    assign big       = (dist_cur == '0) || (size2_reg > {5'b0, dist_cur, 12'b0});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (start) state_next = ST_SQ_SIZE;
            ST_SQ_SIZE:   state_next = ST_SQ_SCALE;
            ST_SQ_SCALE:  state_next = ST_Q_LATCH;
            ST_Q_LATCH:   state_next = ST_VOX_START;
            ST_VOX_START:
            begin
                if (!falloff_enable || saturated)
                    state_next = ST_EMIT;
                else
                    state_next = ST_MUL_MID;
            end
            ST_MUL_MID:   state_next = ST_MUL_S;
            ST_MUL_S:     state_next = ST_CMP;
            ST_CMP:       state_next = (step_reg == '0) ? ST_FINISH : ST_MUL_MID;
            ST_FINISH:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (vox_ready)
                    state_next = last_vox ? ST_UPDATE : ST_VOX_START;
            end
            ST_UPDATE:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ready     = 1'b0;
        vox_valid = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:     ready = 1'b1;
            ST_SQ_SIZE:
            begin
                mul_a = {11'b0, size_reg};
                mul_b = {5'b0, size_reg};
            end
            ST_SQ_SCALE:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = FULL_SCALE;
            end
            ST_MUL_MID:
            begin
                mul_a = {14'b0, trial};
                mul_b = {8'b0, trial};
            end
            ST_MUL_S:
            begin
                mul_a = {6'b0, prod_reg[15:0]};
                mul_b = {11'b0, dist_reg};
            end
            ST_EMIT:     vox_valid = 1'b1;
            default:     ready = 1'b0;
        endcase
    end

    assign vox.x          = x_reg;
    assign vox.y          = y_reg;
    assign vox.z          = z_reg;
    assign vox.brightness = bright_reg;
    assign vox.last       = last_vox;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= '0;
            inv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && start && restart)
            begin
                size_reg <= '0;
                inv_reg  <= 1'b0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                if (size_reg > SIZE_LIMIT)
                begin
                    size_reg <= '0;
                    inv_reg  <= ~inv_reg;
                end
                else
                begin
                    size_reg <= size_reg + SIZE_W'(grow_step);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                x_reg <= '0;
                y_reg <= '0;
                z_reg <= '0;
            end
            ST_SQ_SCALE: size2_reg <= prod_reg[SQ_W-1:0];
            ST_Q_LATCH:  q_reg <= prod_reg;
            ST_VOX_START:
            begin
                dist_reg <= dist_cur;
                b_reg    <= '0;
                step_reg <= SEARCH_W'(BRIGHT_W - 1);
                eq_reg   <= (q_reg == '0);
                if (!falloff_enable)
                    bright_reg <= (big != inv_reg) ? BRIGHT_ON : BRIGHT_OFF;
                else
                    bright_reg <= inv_reg ? BRIGHT_OFF : BRIGHT_ON;
            end
            ST_CMP:
            begin
                // Keep the candidate bit when candidate^2 * dist * 2^14 <= (255 * size)^2.
                if (lhs <= q_reg)
                begin
                    b_reg  <= trial;
                    eq_reg <= (lhs == q_reg);
                end
                step_reg <= step_reg - 1'b1;
            end
            ST_FINISH:
            begin
                if (!inv_reg)
                    bright_reg <= b_reg;
                else if (eq_reg)
                    bright_reg <= BRIGHT_ON - b_reg;
                else
                    bright_reg <= BRIGHT_NEAR - b_reg;
            end
            ST_EMIT:
            begin
                if (vox_ready && !last_vox)
                begin
                    if (z_reg == EDGE_MAX)
                    begin
                        z_reg <= '0;
                        if (y_reg == EDGE_MAX)
                        begin
                            y_reg <= '0;
                            x_reg <= x_reg + 1'b1;
                        end
                        else
                        begin
                            y_reg <= y_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        z_reg <= z_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    a_start_squares: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_SQ_SIZE))
        else $error("accepted frame did not start the size square");

    a_last_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (vox_valid && vox_ready && vox.last) |=> (state_reg == ST_UPDATE))
        else $error("last voxel of a frame was not followed by the size update");

    a_mid_square_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_S) |-> (prod_reg[PROD_W-1:16] == '0))
        else $error("candidate square overflowed its field");

    a_size_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=>
            ((size_reg == '0 && inv_reg != $past(inv_reg)) ||
             (inv_reg == $past(inv_reg) &&
              size_reg == SIZE_W'($past(size_reg) + SIZE_W'($past(grow_step))))))
        else $error("sphere size update went wrong");

endmodule

// ----- rtl/sphere_voxel_brightness_generator.sv -----
// ----------------------------------------------------------------------------
// sphere_voxel_brightness_generator
// Renders one brightness per voxel of a cube for a sphere that grows per frame.
// ----------------------------------------------------------------------------
// Each accepted request is one frame tick and yields 64 voxel results in x, y, z
// order, the last one marked by m_tlast. The size, scale and candidate products
// run on a single shared multiplier: a frame starts by squaring the sphere size,
// scaling the square by 255^2 and latching the result; a voxel that is saturated,
// at the center or in on/off mode is emitted straight after its start step; and a
// graded voxel finds its 8-bit brightness one bit at a time, each bit taking a
// candidate square, a product with the distance and a compare. In the cycle after
// the last voxel is taken the size steps, and s_tready is high again in the cycle
// after that. Output stalls stretch a frame, and s_tready stays low until it ends.
module sphere_voxel_brightness_generator
    import svbg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [0] restart, [7:1] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,    // [1:0] voxel_x, [3:2] voxel_y, [5:4] voxel_z,
                                             // [13:6] brightness, [15:14] zero
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data
);

    logic [STEP_W-1:0] grow_step_reg;
    logic              falloff_reg;
    logic              m_valid_reg;
    voxel_t            out_reg;
    logic              vox_valid;
    logic              vox_ready;
    voxel_t            vox;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_step_reg <= GROW_RESET;
            falloff_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GROW_STEP: grow_step_reg <= cfg_data;
                REG_FALLOFF:   falloff_reg   <= cfg_data[0];
                default:       falloff_reg   <= falloff_reg;
            endcase
        end
    end

    svbg_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (s_tvalid),
        .restart        (s_tdata[0]),
        .ready          (s_tready),
        .grow_step      (grow_step_reg),
        .falloff_enable (falloff_reg),
        .vox_valid      (vox_valid),
        .vox            (vox),
        .vox_ready      (vox_ready)
    );

    // The output register takes a new voxel whenever it is empty or being drained.
    assign vox_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (vox_ready)
        begin
            m_valid_reg <= vox_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vox_ready && vox_valid)
        begin
            out_reg <= vox;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg.brightness, out_reg.z, out_reg.y, out_reg.x};
    assign m_tlast  = out_reg.last;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sphere voxel brightness generator.
// ----------------------------------------------------------------------------
// Frame ticks are queued by the stimulus process and sent in bursts with
// random gaps. Every accepted request is rendered here into its 64 expected
// voxels, and each voxel that leaves the block is compared field by field
// with the oldest one still due. The grow step and the falloff mode are
// changed between phases, only while no frame is in flight.
module tb
    import svbg_pkg::*;
();

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC} ready_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'd0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]    cfg_data  = '0;

    // Shadow copy of the block's state and registers.
    logic [SIZE_W-1:0] model_size     = '0;
    bit                model_inverted = 1'b0;
    logic [STEP_W-1:0] model_step     = GROW_RESET;
    bit                model_falloff  = 1'b1;

    bit     tick_q[$];
    voxel_t voxel_due_q[$];

    int  mismatch_count = 0;
    int  voxel_count    = 0;
    bit  tick_taken     = 1'b0;
    bit  drain_first    = 1'b0;
    int  burst_left     = 1;
    int  gap_left       = 0;

    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_span = 0;
    int          ready_tick = 0;

    sphere_voxel_brightness_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Falloff brightness floor(255 * min(size / d, 1)), or its inverted form, found exactly on squares.
    function automatic logic [BRIGHT_W-1:0] graded_level(
        input logic [SIZE_W-1:0] size,
        input int unsigned       dist4,
        input bit                inv
    );
        longint unsigned sz;
        longint unsigned k;
        longint unsigned t;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        logic [BRIGHT_W-1:0] b;
        sz = size;
        k  = 64'd16384 * dist4;
        if (dist4 == 0 || sz * sz > k)
            return inv ? BRIGHT_OFF : BRIGHT_ON;
        t  = (64'd255 * sz) * (64'd255 * sz);
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * k <= t)
                lo = mid;
            else
                hi = mid - 1;
        end
        b = lo[BRIGHT_W-1:0];
        if (!inv)
            return b;
        // An exact ratio inverts to 255 - b, anything above it truncates one lower.
        return (lo * lo * k == t) ? BRIGHT_ON - b : BRIGHT_NEAR - b;
    endfunction

    function automatic logic [BRIGHT_W-1:0] hard_level(
        input logic [SIZE_W-1:0] size,
        input int unsigned       dist4,
        input bit                inv
    );
        longint unsigned sz;
        bit big;
        sz  = size;
        big = (dist4 == 0) || (sz * sz > 64'd4096 * dist4);
        return (big != inv) ? BRIGHT_ON : BRIGHT_OFF;
    endfunction

    // Renders one frame tick into the queue of due voxels and steps the size.
    function automatic void render_frame(input bit restart);
        voxel_t v;
        int     a;
        int     b;
        int     c;
        int unsigned dist4;
        if (restart)
        begin
            model_size     = '0;
            model_inverted = 1'b0;
        end
        for (int x = 0; x < CUBE_EDGE; x++)
        begin
            for (int y = 0; y < CUBE_EDGE; y++)
            begin
                for (int z = 0; z < CUBE_EDGE; z++)
                begin
                    a     = 2 * x - (CUBE_EDGE - 1);
                    b     = 2 * y - (CUBE_EDGE - 1);
                    c     = 2 * z - (CUBE_EDGE - 1);
                    dist4 = a * a + b * b + c * c;
                    v.x   = COORD_W'(x);
                    v.y   = COORD_W'(y);
                    v.z   = COORD_W'(z);
                    v.brightness = model_falloff
                        ? graded_level(model_size, dist4, model_inverted)
                        : hard_level(model_size, dist4, model_inverted);
                    v.last = (x == CUBE_EDGE - 1) && (y == CUBE_EDGE - 1)
                             && (z == CUBE_EDGE - 1);
                    voxel_due_q.push_back(v);
                end
            end
        end
        if (model_size > SIZE_LIMIT)
        begin
            model_size     = '0;
            model_inverted = ~model_inverted;
        end
        else
        begin
            model_size = model_size + SIZE_W'(model_step);
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("voxel %0d: %s is %0d, should be %0d", voxel_count, field, got, want);
    endtask

    task automatic check_voxel();
        voxel_t want;
        if (voxel_due_q.size() == 0)
        begin
            report_mismatch("unrequested voxel, tdata", m_tdata, 0);
        end
        else
        begin
            want = voxel_due_q.pop_front();
            if (m_tdata[1:0] != want.x)
                report_mismatch("voxel_x", m_tdata[1:0], want.x);
            if (m_tdata[3:2] != want.y)
                report_mismatch("voxel_y", m_tdata[3:2], want.y);
            if (m_tdata[5:4] != want.z)
                report_mismatch("voxel_z", m_tdata[5:4], want.z);
            if (m_tdata[13:6] != want.brightness)
                report_mismatch("brightness", m_tdata[13:6], want.brightness);
            if (m_tlast != want.last)
                report_mismatch("last_voxel", m_tlast, want.last);
        end
        voxel_count++;
    endtask

    // Monitor: both handshakes are sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_voxel();
            if (s_tvalid && s_tready)
            begin
                render_frame(s_tdata[0]);
                tick_taken = 1'b1;
            end
        end
    end

    // Driver: sends frame ticks in bursts, optionally draining the block first.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !tick_taken)
            begin
                // The request is still waiting for s_tready.
            end
            else if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (tick_q.size() == 0 || (drain_first && voxel_due_q.size() != 0))
            begin
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata     <= {7'd0, tick_q.pop_front()};
                s_tvalid    <= 1'b1;
                drain_first = 1'b0;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left  = $urandom_range(1, 6);
                    gap_left    = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 200)
                                                               : $urandom_range(0, 3);
                    drain_first = ($urandom_range(0, 9) == 0);
                end
            end
            tick_taken = 1'b0;
        end
    end

    // Receiver: switches between stretches of full rate, random and periodic stalls.
    always @(negedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            ready_span = $urandom_range(30, 300);
        end
        else
        begin
            ready_span--;
        end
        case (ready_mode)
            RDY_ALWAYS:   m_tready <= 1'b1;
            RDY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            default:      m_tready <= ((ready_tick % 5) < 2);
        endcase
        ready_tick++;
    end

    // Waits until no frame is queued, pending or being rendered.
    task automatic wait_frames_done();
        while (tick_q.size() != 0 || s_tvalid || voxel_due_q.size() != 0)
            @(posedge clk);
        // Leaves time for the size update that follows the last voxel.
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_GROW_STEP)
            model_step = value;
        else if (idx == REG_FALLOFF)
            model_falloff = value[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Upper bits of the falloff write are junk that the block must ignore.
    task automatic configure(input logic [STEP_W-1:0] step, input bit falloff);
        wait_frames_done();
        write_reg(REG_GROW_STEP, step);
        write_reg(REG_FALLOFF, {8'($urandom_range(0, 255)), falloff});
    endtask

    initial
    begin
        logic [STEP_W-1:0] step;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, starting with a restart on a cleared block.
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);

        // Largest step: the size passes the limit quickly and wraps to inverted.
        configure(9'd511, 1'b1);
        repeat (5) tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);

        // On/off sphere through a full wrap, then a restart while inverted.
        configure(9'd256, 1'b0);
        repeat (8) tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);

        configure(9'd26, 1'b0);
        repeat (2) tick_q.push_back(1'b0);
        configure(9'd0, 1'b1);
        repeat (2) tick_q.push_back(1'b0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       step = 9'd26;
                1:       step = 9'd256;
                2:       step = 9'd511;
                3:       step = 9'd0;
                4:       step = GROW_RESET;
                default: step = STEP_W'($urandom_range(26, 256));
            endcase
            configure(step, phase[0]);
            drain_first = 1'b1;
            // Mostly uninterrupted growth so that a nonzero step can reach the wrap.
            repeat (80) tick_q.push_back($urandom_range(0, 15) == 0);
        end

        wait_frames_done();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
